/* rtl/core/sbsg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsg_pkg
// Shared types, register codes, palette and divider constants for the
// color bar / snow pattern generator.
// ----------------------------------------------------------------------------
package sbsg_pkg;

    localparam int DIM_W     = 13;
    localparam int EDGE_W    = 13;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int GEO_CNT_W = 4;

    localparam logic [GEO_CNT_W-1:0] GEO_IDLE       = 4'd0;
    localparam logic [GEO_CNT_W-1:0] GEO_LOAD       = 4'd1;
    localparam logic [GEO_CNT_W-1:0] GEO_FIRST_EDGE = 4'd2;
    localparam logic [GEO_CNT_W-1:0] GEO_LAST       = 4'd8;

    // reciprocals for exact division by a constant over the value ranges used
    localparam logic [16:0] RECIP_7 = 17'd74899;   // n / 7  = n * R >> 19
    localparam logic [14:0] RECIP_3 = 15'd21846;   // n / 3  = n * R >> 16
    localparam logic [13:0] RECIP_6 = 14'd10923;   // n / 6  = n * R >> 16
    localparam int SHIFT_7 = 19;
    localparam int SHIFT_3 = 16;
    localparam int SHIFT_6 = 16;

    localparam logic PAT_SNOW = 1'b1;
    localparam logic FMT_UYVY = 1'b1;

    typedef enum logic [1:0] {
        REG_WIDTH   = 2'd0,
        REG_HEIGHT  = 2'd1,
        REG_PATTERN = 2'd2,
        REG_FORMAT  = 2'd3
    } sbsg_reg_t;

    typedef enum logic [3:0] {
        COL_GRAY    = 4'd0,
        COL_YELLOW  = 4'd1,
        COL_CYAN    = 4'd2,
        COL_GREEN   = 4'd3,
        COL_MAGENTA = 4'd4,
        COL_RED     = 4'd5,
        COL_BLUE    = 4'd6,
        COL_BLACK   = 4'd7,
        COL_MINUS_I = 4'd8,
        COL_WHITE   = 4'd9,
        COL_PLUS_Q  = 4'd10,
        COL_DBLACK  = 4'd11,
        COL_LBLACK  = 4'd12,
        COL_SNOW    = 4'd13
    } sbsg_color_t;

    typedef struct packed {
        logic [5:0][EDGE_W-1:0] bottom;
        logic [1:0][EDGE_W-1:0] band;
        logic [6:0][EDGE_W-1:0] bar;     // entry k holds edge k+1
    } sbsg_geom_t;

    typedef struct packed {
        sbsg_color_t color;
        logic [7:0]  noise;
        logic        uyvy;
        logic        odd;
        logic        line_end;
        logic        frame_end;
    } sbsg_item_t;

    // {r, g, b}
    function automatic logic [23:0] palette_rgb(input sbsg_color_t c);
        logic [23:0] rgb;
        case (c)
            COL_GRAY:    rgb = {8'd191, 8'd191, 8'd191};
            COL_YELLOW:  rgb = {8'd191, 8'd191, 8'd0};
            COL_CYAN:    rgb = {8'd0,   8'd191, 8'd191};
            COL_GREEN:   rgb = {8'd0,   8'd191, 8'd0};
            COL_MAGENTA: rgb = {8'd191, 8'd0,   8'd191};
            COL_RED:     rgb = {8'd191, 8'd0,   8'd0};
            COL_BLUE:    rgb = {8'd0,   8'd0,   8'd191};
            COL_BLACK:   rgb = {8'd19,  8'd19,  8'd19};
            COL_MINUS_I: rgb = {8'd0,   8'd33,  8'd76};
            COL_WHITE:   rgb = {8'd255, 8'd255, 8'd255};
            COL_PLUS_Q:  rgb = {8'd49,  8'd0,   8'd107};
            COL_DBLACK:  rgb = {8'd9,   8'd9,   8'd9};
            COL_LBLACK:  rgb = {8'd29,  8'd29,  8'd29};
            default:     rgb = 24'd0;
        endcase
        return rgb;
    endfunction

endpackage

/* rtl/core/smpte_bar_snow_pattern_generator_unit.sv */
`timescale 1ns / 1ps
// path: an accepted word goes into a queue slot, then into the output register
// throughput: one pixel per clock unless stalled, front and back joined by a two-entry queue
// geometry: bar edges come from one constant multiplier, one bar edge per cycle, so
//   s_tready stays low while edges rebuild after reset and after a width or height write
// reset: rst_n async active low; 640x480, bars, RGB, raster at column 0 row 0
// ----------------------------------------------------------------------------
// smpte_bar_snow_pattern_generator_unit
// Color bar / snow test pattern source with an APB register port.
// ----------------------------------------------------------------------------
module smpte_bar_snow_pattern_generator_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // noise_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // first_byte, second_byte,
                                                     // third_byte, byte_count
    output logic                          m_tlast,   // line_end
    output logic                          m_tuser,   // frame_end
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbsg_pkg::ADDR_W-1:0]   paddr,
    input  logic [sbsg_pkg::DATA_W-1:0]   pwdata,
    output logic [sbsg_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import sbsg_pkg::*;

    logic [DIM_W-1:0] width_reg, height_reg;
    logic             pattern_reg, format_reg;
    logic             wr_en, restart;
    sbsg_reg_t        reg_idx;
    logic             busy, push, pop, q_full, q_empty;
    sbsg_geom_t       geom;
    sbsg_item_t       front_item, back_item;
    logic [7:0]       first_byte, second_byte, third_byte;
    logic [1:0]       byte_count;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W:0]   maxv);
        logic [DIM_W-1:0] res;
        if (v == '0)
        begin
            res = DIM_W'(1);
        end
        else if ({1'b0, v} > maxv)
        begin
            res = DIM_W'(maxv);
        end
        else
        begin
            res = v;
        end
        return res;
    endfunction

    assign pready  = 1'b1;
    assign reg_idx = sbsg_reg_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign restart = wr_en && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= DIM_W'(640);
            height_reg  <= DIM_W'(480);
            pattern_reg <= 1'b0;
            format_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_WIDTH:   width_reg   <= clamp_dim(pwdata[DIM_W-1:0],
                                                      (DIM_W+1)'(MAX_WIDTH));
                REG_HEIGHT:  height_reg  <= clamp_dim(pwdata[DIM_W-1:0],
                                                      (DIM_W+1)'(MAX_HEIGHT));
                REG_PATTERN: pattern_reg <= pwdata[0];
                REG_FORMAT:  format_reg  <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WIDTH:   prdata = DATA_W'(width_reg);
            REG_HEIGHT:  prdata = DATA_W'(height_reg);
            REG_PATTERN: prdata = DATA_W'(pattern_reg);
            REG_FORMAT:  prdata = DATA_W'(format_reg);
            default:     prdata = '0;
        endcase
    end

    sbsg_geom u_geom (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (restart),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .busy         (busy),
        .geom         (geom)
    );

    sbsg_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (restart),
        .busy         (busy),
        .geom         (geom),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .test_pattern (pattern_reg),
        .pixel_format (format_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .noise_byte   (s_tdata),
        .q_full       (q_full),
        .push         (push),
        .item         (front_item)
    );

    sbsg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .item_out (back_item)
    );

    sbsg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .item        (back_item),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .third_byte  (third_byte),
        .byte_count  (byte_count),
        .line_end    (m_tlast),
        .frame_end   (m_tuser)
    );

    assign m_tdata = {6'd0, byte_count, third_byte, second_byte, first_byte};

endmodule

/* rtl/core/sbsg_geom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsg_geom
// Derives bar, band and bottom edges from width and height, one bar edge
// per cycle, the bar edges sharing a single constant multiplier.
// ----------------------------------------------------------------------------
module sbsg_geom (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         restart,
    input  logic [sbsg_pkg::DIM_W-1:0]   frame_width,
    input  logic [sbsg_pkg::DIM_W-1:0]   frame_height,
    output logic                         busy,
    output sbsg_pkg::sbsg_geom_t         geom
);
    import sbsg_pkg::*;

    logic [GEO_CNT_W-1:0] step_reg, step_next;
    logic [15:0]          acc_reg;
    logic [32:0]          bar_prod;
    logic [26:0]          sixth_prod;
    logic [28:0]          band0_prod;
    logic [14:0]          h3;
    logic [EDGE_W-1:0]    sixth_reg;
    logic [EDGE_W-1:0]    twelfth;
    logic [EDGE_W-1:0]    s3;
    logic [2:0]           bar_idx;
    sbsg_geom_t           geom_reg;

    always_comb
    begin
        if (restart)
        begin
            step_next = GEO_LOAD;
        end
        else if (step_reg == GEO_IDLE || step_reg == GEO_LAST)
        begin
            step_next = GEO_IDLE;
        end
        else
        begin
            step_next = step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= GEO_LOAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign bar_prod   = 33'(acc_reg) * 33'(RECIP_7);
    assign sixth_prod = 27'(frame_width) * 27'(RECIP_6);
    assign band0_prod = 29'({frame_height, 1'b0}) * 29'(RECIP_3);
    assign h3         = 15'(frame_height) + 15'({frame_height, 1'b0});
    assign twelfth    = sixth_reg >> 1;
    assign s3         = sixth_reg + {sixth_reg[EDGE_W-2:0], 1'b0};
    assign bar_idx    = 3'(step_reg - GEO_FIRST_EDGE);

    always_ff @(posedge clk)
    begin
        if (step_reg == GEO_LOAD)
        begin
            acc_reg          <= 16'(frame_width);
            sixth_reg        <= EDGE_W'(sixth_prod >> SHIFT_6);
            geom_reg.band[0] <= EDGE_W'(band0_prod >> SHIFT_3);
            geom_reg.band[1] <= EDGE_W'(h3 >> 2);
        end
        else if (step_reg != GEO_IDLE)
        begin
            acc_reg               <= acc_reg + 16'(frame_width);
            geom_reg.bar[bar_idx] <= EDGE_W'(bar_prod >> SHIFT_7);
        end
        if (step_reg == GEO_FIRST_EDGE)
        begin
            geom_reg.bottom[0] <= sixth_reg;
            geom_reg.bottom[1] <= {sixth_reg[EDGE_W-2:0], 1'b0};
            geom_reg.bottom[2] <= s3;
            geom_reg.bottom[3] <= s3 + twelfth;
            geom_reg.bottom[4] <= s3 + {twelfth[EDGE_W-2:0], 1'b0};
            geom_reg.bottom[5] <= s3 + twelfth + {twelfth[EDGE_W-2:0], 1'b0};
        end
    end

    assign busy = (step_reg != GEO_IDLE);
    assign geom = geom_reg;

endmodule

/* rtl/core/sbsg_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsg_front
// Raster counters and region classification; pushes one classified pixel
// per accepted word into the queue.
// ----------------------------------------------------------------------------
module sbsg_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         restart,
    input  logic                         busy,
    input  sbsg_pkg::sbsg_geom_t         geom,
    input  logic [sbsg_pkg::DIM_W-1:0]   frame_width,
    input  logic [sbsg_pkg::DIM_W-1:0]   frame_height,
    input  logic                         test_pattern,
    input  logic                         pixel_format,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   noise_byte,
    input  logic                         q_full,
    output logic                         push,
    output sbsg_pkg::sbsg_item_t         item
);
    import sbsg_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [EDGE_W-1:0] x_ext, y_ext;
    logic [EDGE_W:0]   x_plus, y_plus;
    logic              lend, fend;
    logic [2:0]        bar_idx;
    sbsg_color_t       color;

    assign x_ext  = EDGE_W'(col_reg);
    assign y_ext  = EDGE_W'(row_reg);
    assign x_plus = {1'b0, x_ext} + 14'd1;
    assign y_plus = {1'b0, y_ext} + 14'd1;
    assign lend   = (x_plus >= {1'b0, frame_width});
    assign fend   = lend && (y_plus >= {1'b0, frame_height});

    always_comb
    begin
        bar_idx = 3'd6;
        for (int k = 5; k >= 0; k--)
        begin
            if (x_ext < geom.bar[k])
            begin
                bar_idx = 3'(k);
            end
        end
    end

    always_comb
    begin
        if (test_pattern == PAT_SNOW)
        begin
            color = COL_SNOW;
        end
        else if (y_ext < geom.band[1])
        begin
            if (y_ext < geom.band[0])
            begin
                color = sbsg_color_t'({1'b0, bar_idx});
            end
            else
            begin
                case (bar_idx)
                    3'd0:    color = COL_BLUE;
                    3'd2:    color = COL_MAGENTA;
                    3'd4:    color = COL_CYAN;
                    3'd6:    color = COL_GRAY;
                    default: color = COL_BLACK;
                endcase
            end
        end
        else if (x_ext < geom.bottom[0]) color = COL_MINUS_I;
        else if (x_ext < geom.bottom[1]) color = COL_WHITE;
        else if (x_ext < geom.bottom[2]) color = COL_PLUS_Q;
        else if (x_ext < geom.bottom[3]) color = COL_DBLACK;
        else if (x_ext < geom.bottom[4]) color = COL_BLACK;
        else if (x_ext < geom.bottom[5]) color = COL_LBLACK;
        else color = COL_SNOW;
    end

    assign s_tready = !busy && !q_full;
    assign push     = s_tvalid && s_tready;

    assign item.color     = color;
    assign item.noise     = noise_byte;
    assign item.uyvy      = (pixel_format == FMT_UYVY);
    assign item.odd       = col_reg[0];
    assign item.line_end  = lend;
    assign item.frame_end = fend;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (push)
        begin
            if (lend)
            begin
                col_next = '0;
                row_next = fend ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* rtl/core/sbsg_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsg_queue
// Two-entry queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module sbsg_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sbsg_pkg::sbsg_item_t  item_in,
    input  logic                  pop,
    output logic                  full,
    output logic                  empty,
    output sbsg_pkg::sbsg_item_t  item_out
);
    import sbsg_pkg::*;

    sbsg_item_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign item_out = slot_reg[rd_ptr_reg];

endmodule

/* rtl/core/sbsg_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsg_back
// Palette lookup, YUV conversion and byte packing into the output register.
// ----------------------------------------------------------------------------
module sbsg_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  sbsg_pkg::sbsg_item_t  item,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            first_byte,
    output logic [7:0]            second_byte,
    output logic [7:0]            third_byte,
    output logic [1:0]            byte_count,
    output logic                  line_end,
    output logic                  frame_end
);
    import sbsg_pkg::*;

    localparam logic [15:0] W_YR     = 16'd76;
    localparam logic [15:0] W_YG     = 16'd150;
    localparam logic [15:0] W_YB     = 16'd29;
    localparam logic [15:0] W_UR     = 16'd43;
    localparam logic [15:0] W_UG     = 16'd84;
    localparam logic [15:0] W_UVMAX  = 16'd127;
    localparam logic [15:0] W_VG     = 16'd106;
    localparam logic [15:0] W_VB     = 16'd21;
    localparam logic [16:0] ROUND    = 17'd128;
    localparam logic [7:0]  UV_BIAS  = 8'd128;
    localparam logic [1:0]  CNT_FULL = 2'd3;
    localparam logic [1:0]  CNT_ONE  = 2'd1;

    logic [23:0] rgb;
    logic [7:0]  r, g, b, y, u, v;
    logic [15:0] ys, us, vs;
    logic [16:0] yr, ur, vr;
    logic        valid_reg;
    logic [7:0]  b0_reg, b1_reg, b2_reg, b0_next, b1_next, b2_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        lend_reg, fend_reg;

    assign rgb = (item.color == COL_SNOW) ? {3{item.noise}} : palette_rgb(item.color);
    assign r   = rgb[23:16];
    assign g   = rgb[15:8];
    assign b   = rgb[7:0];

    // 16-bit wrapping sums
    assign ys = 16'(r) * W_YR + 16'(g) * W_YG + 16'(b) * W_YB;
    assign us = 16'(b) * W_UVMAX - 16'(r) * W_UR - 16'(g) * W_UG;
    assign vs = 16'(r) * W_UVMAX - 16'(g) * W_VG - 16'(b) * W_VB;
    assign yr = 17'(ys) + ROUND;
    assign ur = 17'(us) + ROUND;
    assign vr = 17'(vs) + ROUND;
    assign y  = yr[15:8];
    assign u  = ur[15:8] + UV_BIAS;
    assign v  = vr[15:8] + UV_BIAS;

    always_comb
    begin
        if (!item.uyvy)
        begin
            b0_next  = r;
            b1_next  = g;
            b2_next  = b;
            cnt_next = CNT_FULL;
        end
        else if (item.odd)
        begin
            b0_next  = y;
            b1_next  = 8'd0;
            b2_next  = 8'd0;
            cnt_next = CNT_ONE;
        end
        else
        begin
            b0_next  = u;
            b1_next  = y;
            b2_next  = v;
            cnt_next = CNT_FULL;
        end
    end

    assign pop = !q_empty && (!valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b0_reg   <= b0_next;
            b1_reg   <= b1_next;
            b2_reg   <= b2_next;
            cnt_reg  <= cnt_next;
            lend_reg <= item.line_end;
            fend_reg <= item.frame_end;
        end
    end

    assign m_tvalid    = valid_reg;
    assign first_byte  = b0_reg;
    assign second_byte = b1_reg;
    assign third_byte  = b2_reg;
    assign byte_count  = cnt_reg;
    assign line_end    = lend_reg;
    assign frame_end   = fend_reg;

endmodule

/* rtl/core/sbsg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsg_checker
// Port-level checks for the pattern generator, bound to the top level.
// ----------------------------------------------------------------------------
module sbsg_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [31:0]                   m_tdata,
    input logic                          m_tlast,
    input logic                          m_tuser,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [sbsg_pkg::ADDR_W-1:0]   paddr
);
    import sbsg_pkg::*;

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("output word changed while stalled");

    // frame end only on a line end
    a_frame_line: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without line end");

    // single-byte pixel carries zeros in the unused bytes
    a_odd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[25:24] == 2'd1 |-> m_tdata[23:8] == 16'd0)
        else $error("odd pixel with nonzero upper bytes");

    // geometry write stalls the input while edges are rebuilt
    a_geom_stall: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT)
        |=> !s_tready)
        else $error("input accepted during geometry update");

endmodule

bind smpte_bar_snow_pattern_generator_unit sbsg_checker u_sbsg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr)
);
